// ----- hdl/cpe_pkg.sv -----
// Shared types, constants and helper functions of the circle evaluation unit.
`timescale 1ns / 1ps

package cpe_pkg;

  // Number of CORDIC iterations in each of the two rotators.
  localparam int CORDIC_STAGES = 24;
  localparam int TABLE_LEN     = 31;

  // Angle constants in Q4.28.
  localparam logic signed [35:0] TWO_PI  = 36'sd1686629713;
  localparam logic signed [35:0] PI      = 36'sd843314857;
  localparam logic signed [35:0] HALF_PI = 36'sd421657428;
  localparam logic signed [35:0] TIE_TOL = 36'sd4;

  // CORDIC gain compensation in Q30.
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // Arctangent of 2^-i in Q4.28, rounded to nearest.
  localparam logic signed [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd1,         32'sd0
  };

  // Item kinds.
  localparam logic KIND_EVAL   = 1'b0;
  localparam logic KIND_INVERT = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_CENTER_Z    = 3'd2,
    CFG_FIRST_AXIS  = 3'd3,
    CFG_SECOND_AXIS = 3'd4,
    CFG_RADIUS      = 3'd5,
    CFG_DOMAIN_LOW  = 3'd6,
    CFG_DOMAIN_HIGH = 3'd7
  } cfg_idx_e;

  // One input item.
  typedef struct packed {
    logic              kind;
    logic signed [31:0] angle_in;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic              hint_valid;
    logic signed [31:0] hint_angle;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] curvature_x;
    logic signed [31:0] curvature_y;
    logic signed [31:0] curvature_z;
  } result_t;

  // Item data that travels beside the vectoring CORDIC.
  typedef struct packed {
    logic              kind;
    logic signed [31:0] angle_in;
    logic              hint_valid;
    logic signed [31:0] hint_angle;
    logic              zero;
  } vec_side_t;

  // Item data that travels beside the rotation CORDIC.
  typedef struct packed {
    logic              kind;
    logic signed [31:0] angle;
  } rot_side_t;

  // Signed Q2.19 component j of a packed axis.
  function automatic logic signed [20:0] axis_comp(input logic [62:0] axis,
                                                   input logic [1:0] j);
    return $signed(axis[21*j +: 21]);
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // True when two angles lie within the tie tolerance.
  function automatic logic near_eq(input logic signed [35:0] a,
                                   input logic signed [35:0] b);
    logic signed [36:0] d;
    d = 37'(a) - 37'(b);
    return (d <= 37'(TIE_TOL)) && (d >= -37'(TIE_TOL));
  endfunction

endpackage

// ----- hdl/cpe_vec_cordic.sv -----
// Vectoring-mode CORDIC pipeline that turns a normalized vector into its angle.
`timescale 1ns / 1ps

module cpe_vec_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [63:0]    x_i,
  input  logic signed [63:0]    y_i,
  input  logic signed [35:0]    z_i,
  input  cpe_pkg::vec_side_t    side_i,
  output logic                  valid_o,
  output logic signed [35:0]    z_o,
  output cpe_pkg::vec_side_t    side_o
);

  localparam int N = cpe_pkg::CORDIC_STAGES;

  logic signed [63:0] x_w [N];
  logic signed [63:0] y_w [N];
  logic signed [35:0] z_w [N+1];
  logic               vld_w [N+1];
  cpe_pkg::vec_side_t side_w [N+1];

  assign x_w[0]    = x_i;
  assign y_w[0]    = y_i;
  assign z_w[0]    = z_i;
  assign vld_w[0]  = valid_i;
  assign side_w[0] = side_i;

  // One micro-rotation per register stage; the vector is driven toward y = 0.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [63:0] x_d, y_d;
    logic signed [35:0] z_d;
    logic signed [35:0] z_q;
    logic               vld_q;
    cpe_pkg::vec_side_t side_q;

    always_comb begin
      if (y_w[i] > 64'sd0) begin
        x_d = x_w[i] + (y_w[i] >>> i);
        y_d = y_w[i] - (x_w[i] >>> i);
        z_d = z_w[i] + 36'(cpe_pkg::ATAN_TAB[i]);
      end else begin
        x_d = x_w[i] - (y_w[i] >>> i);
        y_d = y_w[i] + (x_w[i] >>> i);
        z_d = z_w[i] - 36'(cpe_pkg::ATAN_TAB[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      z_q    <= z_d;
      side_q <= side_w[i];
    end

    assign z_w[i+1]    = z_q;
    assign vld_w[i+1]  = vld_q;
    assign side_w[i+1] = side_q;

    // The vector itself is not needed after the last iteration.
    if (i < N - 1) begin : g_xy
      logic signed [63:0] x_q, y_q;
      always_ff @(posedge clk_i) begin
        x_q <= x_d;
        y_q <= y_d;
      end
      assign x_w[i+1] = x_q;
      assign y_w[i+1] = y_q;
    end
  end

  assign valid_o = vld_w[N];
  assign z_o     = z_w[N];
  assign side_o  = side_w[N];

endmodule

// ----- hdl/cpe_rot_cordic.sv -----
// Rotation-mode CORDIC pipeline that gives cosine and sine of an angle in Q30.
`timescale 1ns / 1ps

module cpe_rot_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  cpe_pkg::rot_side_t    side_i,
  output logic                  valid_o,
  output logic signed [33:0]    cos_o,
  output logic signed [33:0]    sin_o,
  output cpe_pkg::rot_side_t    side_o
);

  localparam int N = cpe_pkg::CORDIC_STAGES;

  // Range reduction: whole turns into [-pi, pi], then a half-turn fold.
  logic signed [35:0] red_a;
  logic signed [33:0] a_d;
  logic               neg_d;
  always_comb begin
    red_a = 36'(side_i.angle);
    neg_d = 1'b0;
    if (red_a > cpe_pkg::PI) begin
      red_a = red_a - cpe_pkg::TWO_PI;
    end else if (red_a < -cpe_pkg::PI) begin
      red_a = red_a + cpe_pkg::TWO_PI;
    end
    if (red_a > cpe_pkg::HALF_PI) begin
      red_a = red_a - cpe_pkg::PI;
      neg_d = 1'b1;
    end else if (red_a < -cpe_pkg::HALF_PI) begin
      red_a = red_a + cpe_pkg::PI;
      neg_d = 1'b1;
    end
    a_d = red_a[33:0];
  end

  logic               red_vld_q;
  logic signed [33:0] red_a_q;
  logic               red_neg_q;
  cpe_pkg::rot_side_t red_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q <= 1'b0;
    end else begin
      red_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_a_q    <= a_d;
    red_neg_q  <= neg_d;
    red_side_q <= side_i;
  end

  logic signed [33:0] x_w [N+1];
  logic signed [33:0] y_w [N+1];
  logic signed [33:0] a_w [N];
  logic               neg_w [N+1];
  logic               vld_w [N+1];
  cpe_pkg::rot_side_t side_w [N+1];

  assign x_w[0]    = cpe_pkg::GAIN_Q30;
  assign y_w[0]    = 34'sd0;
  assign a_w[0]    = red_a_q;
  assign neg_w[0]  = red_neg_q;
  assign vld_w[0]  = red_vld_q;
  assign side_w[0] = red_side_q;

  // One micro-rotation per register stage; the residual angle is driven to zero.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] x_d, y_d, a_n;
    logic signed [33:0] x_q, y_q;
    logic               neg_q;
    logic               vld_q;
    cpe_pkg::rot_side_t side_q;

    always_comb begin
      if (a_w[i] >= 34'sd0) begin
        x_d = x_w[i] - (y_w[i] >>> i);
        y_d = y_w[i] + (x_w[i] >>> i);
        a_n = a_w[i] - 34'(cpe_pkg::ATAN_TAB[i]);
      end else begin
        x_d = x_w[i] + (y_w[i] >>> i);
        y_d = y_w[i] - (x_w[i] >>> i);
        a_n = a_w[i] + 34'(cpe_pkg::ATAN_TAB[i]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      neg_q  <= neg_w[i];
      side_q <= side_w[i];
    end

    assign x_w[i+1]    = x_q;
    assign y_w[i+1]    = y_q;
    assign neg_w[i+1]  = neg_q;
    assign vld_w[i+1]  = vld_q;
    assign side_w[i+1] = side_q;

    // The residual angle is not needed after the last iteration.
    if (i < N - 1) begin : g_ang
      logic signed [33:0] a_q;
      always_ff @(posedge clk_i) begin
        a_q <= a_n;
      end
      assign a_w[i+1] = a_q;
    end
  end

  // Undo the half-turn fold.
  logic               out_vld_q;
  logic signed [33:0] cos_q, sin_q;
  cpe_pkg::rot_side_t out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_w[N];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q      <= neg_w[N] ? -x_w[N] : x_w[N];
    sin_q      <= neg_w[N] ? -y_w[N] : y_w[N];
    out_side_q <= side_w[N];
  end

  assign valid_o = out_vld_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = out_side_q;

endmodule

// ----- hdl/circle_param_eval_inverse.sv -----
// Top level of the circle evaluation and point projection unit.
`timescale 1ns / 1ps

// Usage:
// The unit holds one configured 3D circle (center, two in-plane axes, radius,
// parameter domain) in registers written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i, one register per write, effective at the next clock edge.
// An item transfer happens at each rising edge with start_i high; busy_o
// stays low, so a new item may enter every cycle. Kind 0 items evaluate the
// circle at angle_in; kind 1 items project a point onto the circle.
// Each item gives one result on result_o, marked by done_o for one cycle,
// in order. The register stages on the path are: projection and
// normalization (7), the vectoring CORDIC (CORDIC_STAGES), angle wrapping
// and the tie check (3), the rotation CORDIC with its fold stages
// (CORDIC_STAGES+2) and the radius scaling with the output register (5).
// Every stage takes a new item each cycle, so throughput is one a cycle.
// Reset clears all valid bits and loads the default circle (unit circle
// around the origin in the x-y plane, domain 0 to 2pi). The receiver takes
// every result as it appears; there is no backpressure.
module circle_param_eval_inverse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cpe_pkg::in_t      in_i,
  output logic              done_o,
  output cpe_pkg::result_t  result_o,
  input  logic              cfg_we_i,
  input  cpe_pkg::cfg_idx_e cfg_idx_i,
  input  logic [62:0]       cfg_wdata_i
);

  // The pipeline never refuses an item.
  assign busy_o = 1'b0;

  // Configuration registers.
  logic signed [31:0] ctr_q [3];
  logic [62:0]        axis1_q, axis2_q;
  logic [30:0]        radius_q;
  logic signed [31:0] dom_lo_q, dom_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= 32'sd0;
      ctr_q[1] <= 32'sd0;
      ctr_q[2] <= 32'sd0;
      axis1_q  <= 63'd524288;
      axis2_q  <= 63'd1099511627776;
      radius_q <= 31'd65536;
      dom_lo_q <= 32'sd0;
      dom_hi_q <= 32'(cpe_pkg::TWO_PI);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpe_pkg::CFG_CENTER_X:    ctr_q[0] <= $signed(cfg_wdata_i[31:0]);
        cpe_pkg::CFG_CENTER_Y:    ctr_q[1] <= $signed(cfg_wdata_i[31:0]);
        cpe_pkg::CFG_CENTER_Z:    ctr_q[2] <= $signed(cfg_wdata_i[31:0]);
        cpe_pkg::CFG_FIRST_AXIS:  axis1_q  <= cfg_wdata_i;
        cpe_pkg::CFG_SECOND_AXIS: axis2_q  <= cfg_wdata_i;
        cpe_pkg::CFG_RADIUS:      radius_q <= cfg_wdata_i[30:0];
        cpe_pkg::CFG_DOMAIN_LOW:  dom_lo_q <= $signed(cfg_wdata_i[31:0]);
        cpe_pkg::CFG_DOMAIN_HIGH: dom_hi_q <= $signed(cfg_wdata_i[31:0]);
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  // Stage 1: spoke from the center to the query point.
  cpe_pkg::in_t       s1_in_q;
  logic signed [32:0] s1_sp_q [3];
  always_ff @(posedge clk_i) begin
    s1_in_q    <= in_i;
    s1_sp_q[0] <= 33'(in_i.point_x) - 33'(ctr_q[0]);
    s1_sp_q[1] <= 33'(in_i.point_y) - 33'(ctr_q[1]);
    s1_sp_q[2] <= 33'(in_i.point_z) - 33'(ctr_q[2]);
  end

  // Stage 2: products of the spoke with both axes.
  cpe_pkg::in_t       s2_in_q;
  logic signed [53:0] s2_px_q [3];
  logic signed [53:0] s2_py_q [3];
  always_ff @(posedge clk_i) begin
    s2_in_q <= s1_in_q;
    for (int j = 0; j < 3; j++) begin
      s2_px_q[j] <= 54'(s1_sp_q[j]) * 54'(cpe_pkg::axis_comp(axis1_q, 2'(j)));
      s2_py_q[j] <= 54'(s1_sp_q[j]) * 54'(cpe_pkg::axis_comp(axis2_q, 2'(j)));
    end
  end

  // Stage 3: projection onto the plane.
  cpe_pkg::in_t       s3_in_q;
  logic signed [55:0] s3_dx_q, s3_dy_q;
  always_ff @(posedge clk_i) begin
    s3_in_q <= s2_in_q;
    s3_dx_q <= 56'(s2_px_q[0]) + 56'(s2_px_q[1]) + 56'(s2_px_q[2]);
    s3_dy_q <= 56'(s2_py_q[0]) + 56'(s2_py_q[1]) + 56'(s2_py_q[2]);
  end

  // Stage 4: larger magnitude of the two coordinates.
  logic [56:0] abs_x, abs_y;
  always_comb begin
    abs_x = s3_dx_q[55] ? 57'(-58'(s3_dx_q)) : 57'(s3_dx_q);
    abs_y = s3_dy_q[55] ? 57'(-58'(s3_dy_q)) : 57'(s3_dy_q);
  end

  cpe_pkg::in_t       s4_in_q;
  logic signed [55:0] s4_dx_q, s4_dy_q;
  logic [56:0]        s4_mag_q;
  always_ff @(posedge clk_i) begin
    s4_in_q  <= s3_in_q;
    s4_dx_q  <= s3_dx_q;
    s4_dy_q  <= s3_dy_q;
    s4_mag_q <= (abs_x > abs_y) ? abs_x : abs_y;
  end

  // Stage 5: leading-one search, upper and lower halves in parallel.
  logic [4:0] enc_hi, enc_lo;
  always_comb begin
    enc_hi = 5'd0;
    enc_lo = 5'd0;
    for (int b = 0; b < 29; b++) begin
      if (s4_mag_q[28 + b]) enc_hi = 5'(b);
    end
    for (int b = 0; b < 28; b++) begin
      if (s4_mag_q[b]) enc_lo = 5'(b);
    end
  end

  cpe_pkg::in_t       s5_in_q;
  logic signed [55:0] s5_dx_q, s5_dy_q;
  logic [4:0]         s5_enc_hi_q, s5_enc_lo_q;
  logic               s5_any_hi_q, s5_any_lo_q;
  always_ff @(posedge clk_i) begin
    s5_in_q     <= s4_in_q;
    s5_dx_q     <= s4_dx_q;
    s5_dy_q     <= s4_dy_q;
    s5_enc_hi_q <= enc_hi;
    s5_enc_lo_q <= enc_lo;
    s5_any_hi_q <= |s4_mag_q[56:28];
    s5_any_lo_q <= |s4_mag_q[27:0];
  end

  // Stage 6: shift count that brings the leading one of the magnitude to bit 58.
  logic [5:0] msb;
  always_comb begin
    msb = s5_any_hi_q ? (6'd28 + 6'(s5_enc_hi_q)) : 6'(s5_enc_lo_q);
  end

  cpe_pkg::in_t       s6_in_q;
  logic signed [55:0] s6_dx_q, s6_dy_q;
  logic [6:0]         s6_shift_q;
  logic               s6_zero_q;
  always_ff @(posedge clk_i) begin
    s6_in_q    <= s5_in_q;
    s6_dx_q    <= s5_dx_q;
    s6_dy_q    <= s5_dy_q;
    s6_shift_q <= 7'd58 - 7'(msb);
    s6_zero_q  <= !s5_any_hi_q && !s5_any_lo_q;
  end

  // Stage 7: normalize and fold the left half-plane onto the right one.
  logic signed [63:0] nx, ny, fx, fy;
  logic signed [35:0] fz;
  always_comb begin
    nx = 64'(s6_dx_q) <<< s6_shift_q;
    ny = 64'(s6_dy_q) <<< s6_shift_q;
    fx = nx;
    fy = ny;
    fz = 36'sd0;
    if (nx < 64'sd0) begin
      if (ny >= 64'sd0) begin
        fx = ny;
        fy = -nx;
        fz = cpe_pkg::HALF_PI;
      end else begin
        fx = -ny;
        fy = nx;
        fz = -cpe_pkg::HALF_PI;
      end
    end
  end

  logic signed [63:0] s7_x_q, s7_y_q;
  logic signed [35:0] s7_z_q;
  cpe_pkg::vec_side_t s7_side_q;
  always_ff @(posedge clk_i) begin
    s7_x_q               <= fx;
    s7_y_q               <= fy;
    s7_z_q               <= fz;
    s7_side_q.kind       <= s6_in_q.kind;
    s7_side_q.angle_in   <= s6_in_q.angle_in;
    s7_side_q.hint_valid <= s6_in_q.hint_valid;
    s7_side_q.hint_angle <= s6_in_q.hint_angle;
    s7_side_q.zero       <= s6_zero_q;
  end

  // Angle of the projected point.
  logic               vec_vld;
  logic signed [35:0] vec_z;
  cpe_pkg::vec_side_t vec_side;

  cpe_vec_cordic u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .x_i     (s7_x_q),
    .y_i     (s7_y_q),
    .z_i     (s7_z_q),
    .side_i  (s7_side_q),
    .valid_o (vec_vld),
    .z_o     (vec_z),
    .side_o  (vec_side)
  );

  // Wrap stage 1: add whole turns until the angle reaches the lower bound.
  logic signed [35:0] up_ang;
  always_comb begin
    up_ang = vec_side.zero ? 36'sd0 : vec_z;
    for (int n = 0; n < 3; n++) begin
      if (up_ang < 36'(dom_lo_q)) up_ang = up_ang + cpe_pkg::TWO_PI;
    end
  end

  logic               w1_vld_q;
  logic signed [35:0] w1_ang_q;
  cpe_pkg::vec_side_t w1_side_q;

  // Wrap stage 2: remove whole turns while above the upper bound.
  logic signed [35:0] dn_ang;
  always_comb begin
    dn_ang = w1_ang_q;
    for (int n = 0; n < 4; n++) begin
      if (36'(dom_hi_q) < dn_ang) dn_ang = dn_ang - cpe_pkg::TWO_PI;
    end
  end

  logic               w2_vld_q;
  logic signed [35:0] w2_ang_q;
  cpe_pkg::vec_side_t w2_side_q;

  // Tie stage: a guess near the other endpoint wins, then saturate; kind 0 items pass angle_in on.
  logic signed [35:0] tie_ang;
  logic signed [35:0] lo_ext, hi_ext, hint_ext;
  cpe_pkg::rot_side_t t_side_d;
  always_comb begin
    lo_ext   = 36'(dom_lo_q);
    hi_ext   = 36'(dom_hi_q);
    hint_ext = 36'(w2_side_q.hint_angle);
    tie_ang  = w2_ang_q;
    if (w2_side_q.hint_valid &&
        ((cpe_pkg::near_eq(w2_ang_q, lo_ext) && cpe_pkg::near_eq(hint_ext, hi_ext)) ||
         (cpe_pkg::near_eq(w2_ang_q, hi_ext) && cpe_pkg::near_eq(hint_ext, lo_ext)))) begin
      tie_ang = hint_ext;
    end
    t_side_d.kind  = w2_side_q.kind;
    if (w2_side_q.kind == cpe_pkg::KIND_EVAL) begin
      t_side_d.angle = w2_side_q.angle_in;
    end else begin
      t_side_d.angle = cpe_pkg::sat32(48'(tie_ang));
    end
  end

  logic               t_vld_q;
  cpe_pkg::rot_side_t t_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_vld_q <= 1'b0;
      w2_vld_q <= 1'b0;
      t_vld_q  <= 1'b0;
    end else begin
      w1_vld_q <= vec_vld;
      w2_vld_q <= w1_vld_q;
      t_vld_q  <= w2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_ang_q  <= up_ang;
    w1_side_q <= vec_side;
    w2_ang_q  <= dn_ang;
    w2_side_q <= w1_side_q;
    t_side_q  <= t_side_d;
  end

  // Cosine and sine of the evaluation angle.
  logic               rot_vld;
  logic signed [33:0] rot_cos, rot_sin;
  cpe_pkg::rot_side_t rot_side;

  cpe_rot_cordic u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_vld_q),
    .side_i  (t_side_q),
    .valid_o (rot_vld),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin),
    .side_o  (rot_side)
  );

  // Valid bits of the back stages.
  logic m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q, m5_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
      m5_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= rot_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      m4_vld_q <= m3_vld_q;
      m5_vld_q <= m4_vld_q;
    end
  end

  // Back stage 1: axis components times cosine and sine.
  cpe_pkg::rot_side_t m1_side_q;
  logic signed [54:0] m1_xc_q [3];
  logic signed [54:0] m1_ys_q [3];
  logic signed [54:0] m1_yc_q [3];
  logic signed [54:0] m1_xs_q [3];
  always_ff @(posedge clk_i) begin
    m1_side_q <= rot_side;
    for (int j = 0; j < 3; j++) begin
      m1_xc_q[j] <= 55'(cpe_pkg::axis_comp(axis1_q, 2'(j))) * 55'(rot_cos);
      m1_ys_q[j] <= 55'(cpe_pkg::axis_comp(axis2_q, 2'(j))) * 55'(rot_sin);
      m1_yc_q[j] <= 55'(cpe_pkg::axis_comp(axis2_q, 2'(j))) * 55'(rot_cos);
      m1_xs_q[j] <= 55'(cpe_pkg::axis_comp(axis1_q, 2'(j))) * 55'(rot_sin);
    end
  end

  // Back stage 2: radial and tangential directions rounded to Q28.
  logic signed [56:0] rad_sum [3];
  logic signed [56:0] tan_sum [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rad_sum[j] = 57'(m1_xc_q[j]) + 57'(m1_ys_q[j]) + (57'sd1 <<< 20);
      tan_sum[j] = 57'(m1_yc_q[j]) - 57'(m1_xs_q[j]) + (57'sd1 <<< 20);
    end
  end

  cpe_pkg::rot_side_t m2_side_q;
  logic signed [35:0] m2_ur_q [3];
  logic signed [35:0] m2_ut_q [3];
  always_ff @(posedge clk_i) begin
    m2_side_q <= m1_side_q;
    for (int j = 0; j < 3; j++) begin
      m2_ur_q[j] <= rad_sum[j][56:21];
      m2_ut_q[j] <= tan_sum[j][56:21];
    end
  end

  // Back stage 3: radius product in two partial products.
  logic signed [16:0] r_lo;
  logic signed [15:0] r_hi;
  assign r_lo = $signed({1'b0, radius_q[15:0]});
  assign r_hi = $signed({1'b0, radius_q[30:16]});

  cpe_pkg::rot_side_t m3_side_q;
  logic signed [52:0] m3_rlo_q [3];
  logic signed [51:0] m3_rhi_q [3];
  logic signed [52:0] m3_tlo_q [3];
  logic signed [51:0] m3_thi_q [3];
  always_ff @(posedge clk_i) begin
    m3_side_q <= m2_side_q;
    for (int j = 0; j < 3; j++) begin
      m3_rlo_q[j] <= 53'(m2_ur_q[j]) * 53'(r_lo);
      m3_rhi_q[j] <= 52'(m2_ur_q[j]) * 52'(r_hi);
      m3_tlo_q[j] <= 53'(m2_ut_q[j]) * 53'(r_lo);
      m3_thi_q[j] <= 52'(m2_ut_q[j]) * 52'(r_hi);
    end
  end

  // Back stage 4: combine the partial products and round to Q16.
  logic signed [67:0] rad_full [3];
  logic signed [67:0] tan_full [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rad_full[j] = (68'(m3_rhi_q[j]) <<< 16) + 68'(m3_rlo_q[j]) + (68'sd1 <<< 27);
      tan_full[j] = (68'(m3_thi_q[j]) <<< 16) + 68'(m3_tlo_q[j]) + (68'sd1 <<< 27);
    end
  end

  cpe_pkg::rot_side_t m4_side_q;
  logic signed [39:0] m4_rad_q [3];
  logic signed [39:0] m4_tan_q [3];
  always_ff @(posedge clk_i) begin
    m4_side_q <= m3_side_q;
    for (int j = 0; j < 3; j++) begin
      m4_rad_q[j] <= rad_full[j][67:28];
      m4_tan_q[j] <= tan_full[j][67:28];
    end
  end

  // Back stage 5: add the center, saturate and register the result.
  logic signed [31:0] pos_d [3];
  logic signed [31:0] tan_d [3];
  logic signed [31:0] cur_d [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pos_d[j] = cpe_pkg::sat32(48'(ctr_q[j]) + 48'(m4_rad_q[j]));
      if (m4_side_q.kind == cpe_pkg::KIND_INVERT) begin
        tan_d[j] = 32'sd0;
        cur_d[j] = 32'sd0;
      end else begin
        tan_d[j] = cpe_pkg::sat32(48'(m4_tan_q[j]));
        cur_d[j] = cpe_pkg::sat32(-48'(m4_rad_q[j]));
      end
    end
  end

  cpe_pkg::result_t m5_res_q;
  always_ff @(posedge clk_i) begin
    m5_res_q.angle_out   <= m4_side_q.angle;
    m5_res_q.pos_x       <= pos_d[0];
    m5_res_q.pos_y       <= pos_d[1];
    m5_res_q.pos_z       <= pos_d[2];
    m5_res_q.tangent_x   <= tan_d[0];
    m5_res_q.tangent_y   <= tan_d[1];
    m5_res_q.tangent_z   <= tan_d[2];
    m5_res_q.curvature_x <= cur_d[0];
    m5_res_q.curvature_y <= cur_d[1];
    m5_res_q.curvature_z <= cur_d[2];
  end

  assign done_o   = m5_vld_q;
  assign result_o = m5_res_q;

  // Checks on the pipeline timing and the angle wrapping.
  localparam int LATENCY = 2 * cpe_pkg::CORDIC_STAGES + 17;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result strobe without an item transfer at the pipeline latency");

  a_wrap_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w1_vld_q && $stable(dom_lo_q)) |-> (w1_ang_q >= 36'(dom_lo_q)))
    else $error("upward wrap left the angle below the lower bound");

  a_wrap_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w2_vld_q && $stable(dom_hi_q)) |-> (w2_ang_q <= 36'(dom_hi_q)))
    else $error("downward wrap left the angle above the upper bound");

endmodule
